// File: src/sha_pkg.sv
package sha_pkg;

	localparam int BlockWords = 16;
	localparam int WordIdxW   = $clog2(BlockWords);
	localparam int Rounds     = 64;
	localparam int RoundW     = $clog2(Rounds);

	localparam logic [7:0] PAD_MARK  = 8'h80;
	localparam logic [5:0] LEN_POS   = 6'd56;
	localparam logic [5:0] LAST_FILL = 6'd63;

	localparam logic [31:0] RoundK [Rounds] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] InitHash [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	// Write request from the front into the block queue.
	typedef struct packed {
		logic                we;
		logic [WordIdxW-1:0] widx;
		logic [31:0]         wdata;
		logic                commit;
		logic                last;
	} blk_wr_t;

	// Read request from the compression core into the block queue.
	typedef struct packed {
		logic [WordIdxW-1:0] ridx;
		logic                rel;
	} blk_rd_t;

	typedef struct packed {
		logic avail;
		logic last;
	} blk_stat_t;

	typedef enum logic {
		FR_IDLE,
		FR_PAD
	} front_state_t;

	typedef enum logic [1:0] {
		CR_IDLE,
		CR_RUN,
		CR_ADD
	} core_state_t;

	function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned k);
		return (x >> k) | (x << (32 - k));
	endfunction

	function automatic logic [31:0] big0(input logic [31:0] x);
		return ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
	endfunction

	function automatic logic [31:0] big1(input logic [31:0] x);
		return ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
	endfunction

	function automatic logic [31:0] sig0(input logic [31:0] x);
		return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] sig1(input logic [31:0] x);
		return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
	endfunction

endpackage

// File: src/sha_front.sv
module sha_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [7:0]        data_byte,
	input  logic              byte_present,
	input  logic              end_of_message,
	input  logic              space,
	output sha_pkg::blk_wr_t  wr
);

	sha_pkg::front_state_t state_q, state_d;
	logic [5:0]  fill_q;
	logic [23:0] acc_q;
	logic [63:0] count_q;
	logic [63:0] len_q;
	logic        pad_first_q;
	logic        len_phase_q;

	logic        accept;
	logic        byte_we;
	logic [7:0]  byte_val;

	always_comb begin
		state_d  = state_q;
		accept   = 1'b0;
		byte_we  = 1'b0;
		byte_val = data_byte;
		full     = 1'b1;
		unique case (state_q)
			sha_pkg::FR_IDLE: begin
				full    = !space;
				accept  = push && space;
				byte_we = accept && byte_present;
				if (accept && end_of_message) begin
					state_d = sha_pkg::FR_PAD;
				end
			end
			sha_pkg::FR_PAD: begin
				byte_we = space;
				// Length bytes go out big-endian, one per position from 56 to 63.
				if (pad_first_q) begin
					byte_val = sha_pkg::PAD_MARK;
				end else if (len_phase_q || fill_q == sha_pkg::LEN_POS) begin
					byte_val = len_q[{~fill_q[2:0], 3'b000} +: 8];
				end else begin
					byte_val = 8'h00;
				end
				if (space && !pad_first_q && len_phase_q && fill_q == sha_pkg::LAST_FILL) begin
					state_d = sha_pkg::FR_IDLE;
				end
			end
			default: begin
				state_d = sha_pkg::FR_IDLE;
			end
		endcase
	end

	always_comb begin
		wr.we     = byte_we && (fill_q[1:0] == 2'b11);
		wr.widx   = fill_q[5:2];
		wr.wdata  = {acc_q, byte_val};
		wr.commit = byte_we && (fill_q == sha_pkg::LAST_FILL);
		wr.last   = (state_q == sha_pkg::FR_PAD) && !pad_first_q && len_phase_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sha_pkg::FR_IDLE;
			fill_q      <= '0;
			count_q     <= '0;
			pad_first_q <= 1'b0;
			len_phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (byte_we) begin
				fill_q <= fill_q + 6'd1;
			end
			if (state_q == sha_pkg::FR_PAD && byte_we) begin
				pad_first_q <= 1'b0;
				if (!pad_first_q && fill_q == sha_pkg::LEN_POS) begin
					len_phase_q <= 1'b1;
				end
			end
			if (accept) begin
				if (end_of_message) begin
					count_q     <= '0;
					pad_first_q <= 1'b1;
					len_phase_q <= 1'b0;
				end else if (byte_present) begin
					count_q <= count_q + 64'd8;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_we) begin
			acc_q <= {acc_q[15:0], byte_val};
		end
		if (accept && end_of_message) begin
			len_q <= byte_present ? count_q + 64'd8 : count_q;
		end
	end

endmodule

// File: src/sha_blkq.sv
module sha_blkq (
	input  logic               clk,
	input  logic               arst_n,
	input  sha_pkg::blk_wr_t   wr,
	input  sha_pkg::blk_rd_t   rd,
	output logic               space,
	output sha_pkg::blk_stat_t stat,
	output logic [31:0]        rdata
);

	localparam int Depth = 2 * sha_pkg::BlockWords;

	logic [31:0] mem [Depth];
	logic [31:0] rdata_q;
	logic [1:0]  busy_q;
	logic [1:0]  last_q;
	logic        wr_ptr_q;
	logic        rd_ptr_q;

	// Two block slots: the front fills one while the core reads the other.
	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[{wr_ptr_q, wr.widx}] <= wr.wdata;
		end
		rdata_q <= mem[{rd_ptr_q, rd.ridx}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= '0;
			last_q   <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (wr.commit) begin
				busy_q[wr_ptr_q] <= 1'b1;
				last_q[wr_ptr_q] <= wr.last;
				wr_ptr_q         <= !wr_ptr_q;
			end
			if (rd.rel) begin
				busy_q[rd_ptr_q] <= 1'b0;
				rd_ptr_q         <= !rd_ptr_q;
			end
		end
	end

	assign space      = !busy_q[wr_ptr_q];
	assign stat.avail = busy_q[rd_ptr_q];
	assign stat.last  = last_q[rd_ptr_q];
	assign rdata      = rdata_q;

endmodule

// File: src/sha_core.sv
module sha_core (
	input  logic               clk,
	input  logic               arst_n,
	input  sha_pkg::blk_stat_t stat,
	input  logic [31:0]        rdata,
	output sha_pkg::blk_rd_t   rd,
	input  logic               pop,
	output logic               empty,
	output logic [31:0]        digest_word,
	output logic [2:0]         word_index,
	output logic               last_word
);

	sha_pkg::core_state_t state_q, state_d;
	logic [sha_pkg::RoundW-1:0] rnd_q;
	logic        last_blk_q;
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [sha_pkg::BlockWords];
	logic [31:0] dig_q [8];
	logic        out_pend_q;
	logic [2:0]  out_idx_q;

	logic        start;
	logic [31:0] w_cur;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] ch;
	logic [31:0] maj;

	// The first sixteen rounds take message words straight from the queue.
	always_comb begin
		if (rnd_q < sha_pkg::RoundW'(sha_pkg::BlockWords)) begin
			w_cur = rdata;
		end else begin
			w_cur = w_q[0] + sha_pkg::sig0(w_q[1]) + w_q[9] + sha_pkg::sig1(w_q[14]);
		end
		ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1  = v_q[7] + sha_pkg::big1(v_q[4]) + ch + sha_pkg::RoundK[rnd_q] + w_cur;
		t2  = sha_pkg::big0(v_q[0]) + maj;
	end

	always_comb begin
		state_d = state_q;
		start   = 1'b0;
		rd.ridx = '0;
		rd.rel  = 1'b0;
		unique case (state_q)
			sha_pkg::CR_IDLE: begin
				// A final block waits until the previous digest has been drained.
				if (stat.avail && !(stat.last && out_pend_q)) begin
					start   = 1'b1;
					state_d = sha_pkg::CR_RUN;
				end
			end
			sha_pkg::CR_RUN: begin
				rd.ridx = rnd_q[sha_pkg::WordIdxW-1:0] + sha_pkg::WordIdxW'(1);
				rd.rel  = (rnd_q == sha_pkg::RoundW'(sha_pkg::BlockWords - 1));
				if (rnd_q == sha_pkg::RoundW'(sha_pkg::Rounds - 1)) begin
					state_d = sha_pkg::CR_ADD;
				end
			end
			sha_pkg::CR_ADD: begin
				state_d = sha_pkg::CR_IDLE;
			end
			default: begin
				state_d = sha_pkg::CR_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= sha_pkg::CR_IDLE;
			rnd_q      <= '0;
			out_pend_q <= 1'b0;
			out_idx_q  <= '0;
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= sha_pkg::InitHash[i];
			end
		end else begin
			state_q <= state_d;
			if (start) begin
				rnd_q <= '0;
			end else if (state_q == sha_pkg::CR_RUN) begin
				rnd_q <= rnd_q + sha_pkg::RoundW'(1);
			end
			if (state_q == sha_pkg::CR_ADD) begin
				for (int i = 0; i < 8; i++) begin
					h_q[i] <= last_blk_q ? sha_pkg::InitHash[i] : h_q[i] + v_q[i];
				end
			end
			// A final block only starts with no digest pending, so a pop never meets a new digest.
			if (state_q == sha_pkg::CR_ADD && last_blk_q) begin
				out_pend_q <= 1'b1;
				out_idx_q  <= '0;
			end else if (pop && out_pend_q) begin
				out_idx_q <= out_idx_q + 3'd1;
				if (out_idx_q == 3'd7) begin
					out_pend_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			last_blk_q <= stat.last;
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= h_q[i];
			end
		end else if (state_q == sha_pkg::CR_RUN) begin
			v_q[0] <= t1 + t2;
			v_q[1] <= v_q[0];
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3] + t1;
			v_q[5] <= v_q[4];
			v_q[6] <= v_q[5];
			v_q[7] <= v_q[6];
			for (int i = 0; i < sha_pkg::BlockWords - 1; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[sha_pkg::BlockWords - 1] <= w_cur;
		end
		if (state_q == sha_pkg::CR_ADD && last_blk_q) begin
			for (int i = 0; i < 8; i++) begin
				dig_q[i] <= h_q[i] + v_q[i];
			end
		end
	end

	assign empty       = !out_pend_q;
	assign digest_word = dig_q[out_idx_q];
	assign word_index  = out_idx_q;
	assign last_word   = (out_idx_q == 3'd7);

endmodule

// File: src/sha256_byte_stream_hasher.sv
// SHA-256 over a byte stream. Each request may carry one message byte and may close the
// message; a closing request yields eight digest words, h0 first, after which the hasher
// starts a new message from the initial hash. Incoming bytes are taken one per cycle
// while the queue has space, into a two-slot block queue; the compression core handles
// each 64-byte block in a start step, one round per cycle and a final-add step, so the
// front can fill one slot while the core compresses the other, and push is held off by
// full whenever both slots are occupied. After a closing request the front generates 9 to
// 72 padding bytes at one per cycle while space allows, and takes no requests meanwhile.
// A final block is not compressed until the previous digest has been fully popped.
module sha256_byte_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        byte_present,
	input  logic        end_of_message,
	output logic        empty,
	input  logic        pop,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	sha_pkg::blk_wr_t   wr;
	sha_pkg::blk_rd_t   rd;
	sha_pkg::blk_stat_t stat;
	logic               space;
	logic [31:0]        rdata;

	sha_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.data_byte      (data_byte),
		.byte_present   (byte_present),
		.end_of_message (end_of_message),
		.space          (space),
		.wr             (wr)
	);

	sha_blkq u_blkq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.rd     (rd),
		.space  (space),
		.stat   (stat),
		.rdata  (rdata)
	);

	sha_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.stat        (stat),
		.rdata       (rdata),
		.rd          (rd),
		.pop         (pop),
		.empty       (empty),
		.digest_word (digest_word),
		.word_index  (word_index),
		.last_word   (last_word)
	);

endmodule
